// ===== rtl/slpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpq_pkg
// shared types and codes of the sorted-list priority queue
// ----------------------------------------------------------------------------
package slpq_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CHANGE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_UNCHANGED = 3'd4;

    localparam logic [1:0] REL_LT = 2'd0;
    localparam logic [1:0] REL_LE = 2'd1;
    localparam logic [1:0] REL_GT = 2'd2;
    localparam logic [1:0] REL_GE = 2'd3;

    function automatic logic walk_past(input logic [1:0] mode,
                                       input logic signed [31:0] have,
                                       input logic signed [31:0] want);
        logic r;
        case (mode)
            REL_LT:  r = have < want;
            REL_LE:  r = have <= want;
            REL_GT:  r = have > want;
            default: r = have >= want;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/slpq_free_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpq_free_map
// used-slot map with lowest-free-slot search, one slot checked per cycle
// ----------------------------------------------------------------------------
module slpq_free_map #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_set,
    input  logic                        i_clr,
    input  logic [$clog2(CAPACITY)-1:0] i_slot,
    input  logic                        i_start,
    output logic                        o_done,
    output logic [$clog2(CAPACITY)-1:0] o_free
);
    localparam int SW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] r_used;
    logic [SW-1:0]       r_idx;
    logic                r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (i_set) r_used[i_slot] <= 1'b1;
            if (i_clr) r_used[i_slot] <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (!r_used[r_idx]) r_busy <= 1'b0;
                else r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_done = r_busy && !r_used[r_idx];
    assign o_free = r_idx;
endmodule

// ===== rtl/sorted_list_priority_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_priority_queue_core
// bounded priority queue held as a doubly linked list in slot memory
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata {priority_in, element_in}, tuser kind
// m_axis    out  m_axis_tvalid/tready      tdata status..entry_count
// cfg       in   i_cfg_valid/o_cfg_ready   relation_mode
//
// remove: reads the head node, unlinks it, then reads the new head for the top fields
// insert: free-slot search one slot per cycle, then the list walk, a memory read
// then a compare per node (states RD, CMP)
// change walks the list to find the element and, if its priority differs, again to reinsert it
// reset is synchronous and empties the queue at once; no clearing pass
// one item at a time; the next item is taken while the previous result waits
module sorted_list_priority_queue_core
    import slpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // element_in, priority_in
    input  logic [1:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,  // status, element_out, priority_out,
                                        // top_element, top_priority, is_empty,
                                        // entry_count, zero fill
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_data
);
    localparam int SW = $clog2(CAPACITY);
    localparam int LW = SW + 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FREE   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_LINK   = 4'd4;
    localparam logic [3:0] S_FIXPRV = 4'd5;
    localparam logic [3:0] S_FIXNXT = 4'd6;
    localparam logic [3:0] S_UNL_P  = 4'd7;
    localparam logic [3:0] S_UNL_N  = 4'd8;
    localparam logic [3:0] S_HEAD   = 4'd9;
    localparam logic [3:0] S_HEADW  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;
    localparam logic [3:0] S_FIND   = 4'd12;
    localparam logic [3:0] S_FINDC  = 4'd13;
    localparam logic [3:0] S_REMR   = 4'd14;
    localparam logic [3:0] S_REMW   = 4'd15;

    // node memory: element, priority, next, prev
    logic [31:0]   m_elem [CAPACITY];
    logic [31:0]   m_prio [CAPACITY];
    logic [LW-1:0] m_next [CAPACITY];
    logic [LW-1:0] m_prev [CAPACITY];

    logic          mw_en;
    logic [SW-1:0] mw_addr;
    logic [3:0]    mw_mask; // elem, prio, next, prev
    logic [31:0]   mw_elem, mw_prio;
    logic [LW-1:0] mw_next, mw_prev;
    logic [SW-1:0] mr_addr;
    logic [31:0]   rd_elem, rd_prio;
    logic [LW-1:0] rd_next, rd_prev;

    always_ff @(posedge i_clk) begin
        if (mw_en) begin
            if (mw_mask[0]) m_elem[mw_addr] <= mw_elem;
            if (mw_mask[1]) m_prio[mw_addr] <= mw_prio;
            if (mw_mask[2]) m_next[mw_addr] <= mw_next;
            if (mw_mask[3]) m_prev[mw_addr] <= mw_prev;
        end
        rd_elem <= m_elem[mr_addr];
        rd_prio <= m_prio[mr_addr];
        rd_next <= m_next[mr_addr];
        rd_prev <= m_prev[mr_addr];
    end

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_mode;
    logic [1:0]    r_kind;
    logic [31:0]   r_e, r_p;
    logic [LW-1:0] r_head, r_cur, r_before, r_slot, r_un_p, r_un_n;
    logic [CW-1:0] r_cnt;
    logic [2:0]    r_status;
    logic [31:0]   r_eout, r_pout, r_old, r_te, r_tp;
    logic          r_found;
    logic [CW-1:0] r_steps;
    logic          r_ovalid;
    logic [143:0]  r_odata;

    logic          fm_start, fm_done, fm_set, fm_clr;
    logic [SW-1:0] fm_free, fm_slot;

    slpq_free_map #(.CAPACITY(CAPACITY)) u_free (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_set(fm_set), .i_clr(fm_clr),
        .i_slot(fm_slot), .i_start(fm_start), .o_done(fm_done), .o_free(fm_free)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    wire acc = s_axis_tvalid && s_axis_tready;

    function automatic logic [SW-1:0] sa(input logic [LW-1:0] v);
        return v[SW-1:0];
    endfunction

    always_comb begin
        mw_en = 1'b0; mw_addr = sa(r_slot); mw_mask = 4'b0;
        mw_elem = r_e; mw_prio = r_p; mw_next = r_cur; mw_prev = r_before;
        mr_addr = sa(r_cur);
        fm_start = 1'b0; fm_set = 1'b0; fm_clr = 1'b0; fm_slot = sa(r_slot);
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (s_axis_tuser)
                        KIND_INSERT: begin
                            if (r_cnt >= CW'(CAPACITY)) n_state = S_HEAD;
                            else begin
                                fm_start = 1'b1; n_state = S_FREE;
                            end
                        end
                        KIND_REMOVE: n_state = (r_cnt == '0) ? S_OUT : S_REMR;
                        KIND_CHANGE: n_state = S_FIND;
                        default:     n_state = S_HEAD;
                    endcase
                end
            end
            S_FREE: if (fm_done) n_state = S_RD;
            S_RD: begin
                if (r_cur == NIL || r_steps == CW'(CAPACITY)) n_state = S_LINK;
                else n_state = S_CMP;
            end
            S_CMP: begin
                if (walk_past(r_mode, rd_prio, r_p)) n_state = S_RD;
                else n_state = S_LINK;
            end
            S_LINK: begin
                mw_en = 1'b1; mw_mask = 4'b1111;
                fm_set = 1'b1;
                n_state = S_FIXPRV;
            end
            S_FIXPRV: begin
                if (r_before != NIL) begin
                    mw_en = 1'b1; mw_addr = sa(r_before); mw_mask = 4'b0100;
                    mw_next = r_slot;
                end
                n_state = S_FIXNXT;
            end
            S_FIXNXT: begin
                if (r_cur != NIL) begin
                    mw_en = 1'b1; mw_addr = sa(r_cur); mw_mask = 4'b1000;
                    mw_prev = r_slot;
                end
                n_state = S_HEAD;
            end
            S_REMR: begin
                mr_addr = sa(r_head); n_state = S_REMW;
            end
            S_REMW: begin
                fm_clr = 1'b1; fm_slot = sa(r_head);
                n_state = S_UNL_P;
            end
            S_FIND: begin
                if (r_cur == NIL || r_steps == CW'(CAPACITY)) n_state = S_HEAD;
                else n_state = S_FINDC;
            end
            S_FINDC: begin
                if (rd_elem == r_e && rd_prio != r_p) n_state = S_UNL_P;
                else n_state = S_FIND;
            end
            S_UNL_P: begin
                if (r_un_p != NIL) begin
                    mw_en = 1'b1; mw_addr = sa(r_un_p); mw_mask = 4'b0100;
                    mw_next = r_un_n;
                end
                n_state = S_UNL_N;
            end
            S_UNL_N: begin
                if (r_un_n != NIL) begin
                    mw_en = 1'b1; mw_addr = sa(r_un_n); mw_mask = 4'b1000;
                    mw_prev = r_un_p;
                end
                n_state = (r_kind == KIND_CHANGE) ? S_RD : S_HEAD;
            end
            S_HEAD: begin
                mr_addr = sa(r_head); n_state = S_HEADW;
            end
            S_HEADW: n_state = S_OUT;
            S_OUT:   if (!r_ovalid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_FIND && !(r_cur == NIL || r_steps == CW'(CAPACITY)))
            mr_addr = sa(r_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= REL_GE;
            r_head   <= NIL;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_mode <= i_cfg_data;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (acc) begin
                    r_kind <= s_axis_tuser;
                    r_e <= s_axis_tdata[31:0];
                    r_p <= s_axis_tdata[63:32];
                    r_status <= ST_OK; r_eout <= '0; r_pout <= '0;
                    r_found <= 1'b0; r_steps <= '0;
                    r_cur <= r_head; r_before <= NIL;
                    r_te <= '0; r_tp <= '0;
                    if (s_axis_tuser == KIND_INSERT && r_cnt >= CW'(CAPACITY))
                        r_status <= ST_FULL;
                    if (s_axis_tuser == KIND_REMOVE && r_cnt == '0) begin
                        r_status <= ST_EMPTY;
                    end
                end
                S_FREE: if (fm_done) r_slot <= {1'b0, fm_free};
                S_RD: r_steps <= r_steps + 1'b1;
                S_CMP: if (walk_past(r_mode, rd_prio, r_p)) begin
                    r_before <= r_cur; r_cur <= rd_next;
                end
                S_LINK: begin
                    if (r_before == NIL) r_head <= r_slot;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_REMW: begin
                    r_eout <= rd_elem; r_pout <= rd_prio;
                    r_un_p <= rd_prev; r_un_n <= rd_next;
                    r_slot <= r_head;
                    r_head <= (rd_next != NIL) ? rd_next : NIL;
                    r_cnt <= r_cnt - 1'b1;
                end
                S_FIND: begin
                    r_steps <= r_steps + 1'b1;
                    if (r_cur == NIL || r_steps == CW'(CAPACITY)) begin
                        r_status <= r_found ? ST_UNCHANGED : ST_NOT_FOUND;
                        r_pout <= r_found ? r_old : '0;
                    end
                end
                S_FINDC: begin
                    if (rd_elem == r_e) begin
                        r_found <= 1'b1; r_old <= rd_prio;
                    end
                    if (rd_elem == r_e && rd_prio != r_p) begin
                        r_pout <= rd_prio;
                        r_slot <= r_cur;
                        r_un_p <= rd_prev; r_un_n <= rd_next;
                        if (rd_prev == NIL) r_head <= rd_next;
                        r_cnt <= r_cnt - 1'b1;
                    end else r_cur <= rd_next;
                end
                S_UNL_N: if (r_kind == KIND_CHANGE) begin
                    r_cur <= r_head; r_before <= NIL; r_steps <= '0;
                end
                S_HEADW: if (r_cnt != '0) begin
                    r_te <= rd_elem; r_tp <= rd_prio;
                end
                S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_odata <= {5'b0, 7'(r_cnt), (r_cnt == '0), r_tp, r_te,
                                r_pout, r_eout, r_status};
                end
                default: ;
            endcase
        end
    end
endmodule
